[src/rom_pkg.sv]
package rom_pkg;

  // Configuration register indexes.
  localparam logic [0:0] REG_SUBS_IN_USE = 1'b0;
  localparam logic [0:0] REG_DIMS_IN_USE = 1'b1;

  // Function codes of an input beat.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  // Reach of the dim field.
  localparam int FIELD_DIMS = 4;

  // Width of the configuration data port.
  localparam int CFG_BITS = 7;

  // Input beat.
  typedef struct packed {
    logic               func;
    logic [5:0]         slot;
    logic [1:0]         dim;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic [15:0]        update_id;
  } req_t;

  // Output beat.
  typedef struct packed {
    logic [15:0] result_id;
    logic [63:0] match_mask;
  } rsp_t;

  // Token that travels down the chain with each accepted beat.
  typedef struct packed {
    logic       valid;
    logic       active;   // beat whose dimension is in use
    logic       last;     // final dimension of the update
    logic [6:0] subs;     // effective subscription count taken at entry
    req_t       beat;
  } tok_t;

endpackage

[src/region_overlap_matcher_unit.sv]
// Brute-force region matcher built as a chain of MAX_SUBS cells, one per
// subscription slot. Every accepted beat, load or update extent, enters
// cell 0 and moves one cell per cycle while the chain advances; each cell
// stores its slot's edges and keeps its own running match bit, setting its
// bit of the mask as the beat passes. A new beat is taken every cycle while
// the output register is free or being emptied, so the block sustains one
// beat per cycle; the cell chain and the output register make MAX_SUBS + 1
// stages, and the first of them loads at the edge that accepts a beat.
// Dimension and subscription counts are sampled as a beat enters, so
// configuration may be written once the last result has been taken.
module region_overlap_matcher_unit #(
  parameter int MAX_SUBS   = 64,
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [rom_pkg::CFG_BITS-1:0]   cfg_data,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  rom_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output rom_pkg::rsp_t                  rsp
);
  import rom_pkg::*;

  localparam int CW   = (COORD_BITS > 32) ? 32 : COORD_BITS;
  localparam int DCAP = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;

  logic [6:0] subs_in_use;
  logic [2:0] dims_in_use;
  logic [2:0] nd;
  logic [6:0] subs_eff;
  logic       adv;
  tok_t       entry;

  tok_t                tok_chain  [MAX_SUBS+1];
  logic [MAX_SUBS-1:0] mask_chain [MAX_SUBS+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      subs_in_use <= 7'd0;
      dims_in_use <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SUBS_IN_USE: subs_in_use <= cfg_data[6:0];
        REG_DIMS_IN_USE: dims_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Effective counts and the entry token.
  always_comb begin
    if (dims_in_use == 3'd0) begin
      nd = 3'd1;
    end else if (int'(dims_in_use) > DCAP) begin
      nd = 3'(DCAP);
    end else begin
      nd = dims_in_use;
    end
    subs_eff     = (int'(subs_in_use) > MAX_SUBS) ? 7'(MAX_SUBS) : subs_in_use;
    entry.valid  = req_valid;
    entry.active = ({1'b0, req.dim} < nd);
    entry.last   = (({1'b0, req.dim} + 3'd1) == nd);
    entry.subs   = subs_eff;
    entry.beat   = req;
  end

  assign req_stall     = !adv;
  assign tok_chain[0]  = entry;
  assign mask_chain[0] = '1;

  // The row of cells.
  for (genvar g = 0; g < MAX_SUBS; g++) begin : g_cell
    rom_cell #(
      .IDX      (g),
      .MAX_SUBS (MAX_SUBS),
      .MAX_DIMS (MAX_DIMS),
      .CW       (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .tok_in   (tok_chain[g]),
      .mask_in  (mask_chain[g]),
      .tok_out  (tok_chain[g+1]),
      .mask_out (mask_chain[g+1])
    );
  end

  // Result register at the end of the chain.
  rom_outreg #(
    .MAX_SUBS (MAX_SUBS)
  ) u_outreg (
    .clk       (clk),
    .rst       (rst),
    .tok_in    (tok_chain[MAX_SUBS]),
    .mask_in   (mask_chain[MAX_SUBS]),
    .adv       (adv),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // A result only follows a final-dimension update leaving the chain.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(tok_chain[MAX_SUBS].valid && tok_chain[MAX_SUBS].last &&
                               tok_chain[MAX_SUBS].active))
    else $error("result without a completed update");

  // With the output register empty the block takes input.
  assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("input stalled while output is empty");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    $fell(rst) |-> !rsp_valid)
    else $error("result pending after reset");

endmodule

[src/rom_cell.sv]
module rom_cell #(
  parameter int IDX        = 0,
  parameter int MAX_SUBS   = 64,
  parameter int MAX_DIMS   = 4,
  parameter int CW         = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  rom_pkg::tok_t       tok_in,
  input  logic [MAX_SUBS-1:0] mask_in,
  output rom_pkg::tok_t       tok_out,
  output logic [MAX_SUBS-1:0] mask_out
);
  import rom_pkg::*;

  localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  // Edges of this cell's subscription, one entry per dimension.
  logic signed [CW-1:0] low_mem  [MAX_DIMS];
  logic signed [CW-1:0] high_mem [MAX_DIMS];

  logic                 run;
  logic                 hit;
  logic                 load;
  logic [IW-1:0]        didx;
  logic signed [CW-1:0] ul, uu, sl, sh;
  logic                 ovl;
  logic                 match;
  logic [MAX_SUBS-1:0]  mask_next;

  // Decode what the passing beat means for this cell.
  always_comb begin
    didx  = IW'(tok_in.beat.dim);
    ul    = tok_in.beat.lower[CW-1:0];
    uu    = tok_in.beat.upper[CW-1:0];
    sl    = low_mem[didx];
    sh    = high_mem[didx];
    hit   = tok_in.valid && (tok_in.beat.func == FUNC_UPDATE) && tok_in.active;
    load  = tok_in.valid && (tok_in.beat.func == FUNC_LOAD) &&
            (tok_in.beat.slot == 6'(IDX)) && (int'(tok_in.beat.dim) < MAX_DIMS);
  end

  // Edge containment test in either direction.
  always_comb begin
    ovl = ((ul <= sl) && (sl <= uu)) || ((ul <= sh) && (sh <= uu)) ||
          ((sl <= ul) && (ul <= sh)) || ((sl <= uu) && (uu <= sh));
    match = ((tok_in.beat.dim == 2'd0) ? 1'b1 : run) && ovl;
  end

  // This cell's bit of the mask follows its match on an update in use.
  always_comb begin
    mask_next      = mask_in;
    mask_next[IDX] = hit ? match : mask_in[IDX];
  end

  // Running match bit for this subscription; restarts after the final dimension.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b1;
    end else if (en && hit) begin
      run <= tok_in.last ? 1'b1 : match;
    end
  end

  // Subscription store.
  always_ff @(posedge clk) begin
    if (en && load) begin
      low_mem[didx]  <= ul;
      high_mem[didx] <= uu;
    end
  end

  // Hand the beat and its mask on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out  <= '0;
      mask_out <= '0;
    end else if (en) begin
      tok_out  <= tok_in;
      mask_out <= mask_next;
    end
  end

endmodule

[src/rom_outreg.sv]
module rom_outreg #(
  parameter int MAX_SUBS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  rom_pkg::tok_t       tok_in,
  input  logic [MAX_SUBS-1:0] mask_in,
  output logic                adv,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rom_pkg::rsp_t       rsp
);
  import rom_pkg::*;

  logic [MAX_SUBS-1:0] keep;
  logic                done;

  // The chain moves whenever the output register is free or being emptied.
  assign adv  = !rsp_valid || !rsp_stall;
  assign done = tok_in.valid && (tok_in.beat.func == FUNC_UPDATE) &&
                tok_in.active && tok_in.last;

  // Clear slots at or above the subscription count.
  always_comb begin
    for (int j = 0; j < MAX_SUBS; j++) begin
      keep[j] = (7'(j) < tok_in.subs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && done) begin
      rsp.result_id  <= tok_in.beat.update_id;
      rsp.match_mask <= 64'(mask_in & keep);
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import rom_pkg::*;

  localparam int SLOTS = 64;
  localparam int DIMS = 4;
  localparam int N_PHASES = 10;
  localparam int BEATS_PER_PHASE = 85;
  // Margin for the chain and output register to empty; leave some margin.
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;

  // Register settings of the random phases, the extremes among them.
  localparam bit [CFG_BITS-1:0] PHASE_SUBS [N_PHASES] =
    '{7'd64, 7'd0, 7'd127, 7'd1, 7'd37, 7'd64, 7'd9, 7'd100, 7'd64, 7'd22};
  localparam bit [CFG_BITS-1:0] PHASE_DIMS [N_PHASES] =
    '{7'd4, 7'd1, 7'd7, 7'd0, 7'd3, 7'd2, 7'd4, 7'd5, 7'd2, 7'd3};

  // Keeps a copy of the subscription edges and the running mask, and holds the
  // match results still owed by the block.
  class match_tracker;
    bit signed [31:0] sub_lo [SLOTS][DIMS];
    bit signed [31:0] sub_hi [SLOTS][DIMS];
    bit [63:0] live_mask;
    bit [CFG_BITS-1:0] subs_reg;
    bit [2:0] dims_reg;
    rsp_t expected_matches [$];
    int errors;

    function new();
      live_mask = {64{1'b1}};
      subs_reg = 0;
      dims_reg = 1;
      errors = 0;
    endfunction

    function void write_reg(logic [0:0] index, logic [CFG_BITS-1:0] value);
      if (index == REG_SUBS_IN_USE) subs_reg = value;
      else dims_reg = value[2:0];
    endfunction

    // A count of zero behaves as one; larger counts saturate at the dim reach.
    function int dims_now();
      if (dims_reg == 0) return 1;
      if (dims_reg > DIMS) return DIMS;
      return dims_reg;
    endfunction

    // Either interval holds an edge of the other.
    function bit touches(bit signed [31:0] ul, bit signed [31:0] uu,
                         bit signed [31:0] sl, bit signed [31:0] sh);
      return (ul <= sl && sl <= uu) || (ul <= sh && sh <= uu) ||
             (sl <= ul && ul <= sh) || (sl <= uu && uu <= sh);
    endfunction

    // Applies one accepted input beat and queues the result it causes, if any.
    function void take_extent(req_t b);
      int nd;
      int ns;
      bit [63:0] m;
      bit [63:0] keep;
      rsp_t r;
      if (b.func == FUNC_LOAD) begin
        sub_lo[b.slot][b.dim] = b.lower;
        sub_hi[b.slot][b.dim] = b.upper;
        return;
      end
      nd = dims_now();
      if (int'(b.dim) >= nd) return;
      // Dimension 0 always starts a fresh update.
      m = (b.dim == 0) ? {64{1'b1}} : live_mask;
      for (int j = 0; j < SLOTS; j++) begin
        if (!touches(b.lower, b.upper, sub_lo[j][b.dim], sub_hi[j][b.dim]))
          m[j] = 1'b0;
      end
      if (int'(b.dim) + 1 < nd) begin
        live_mask = m;
        return;
      end
      ns = (subs_reg > SLOTS) ? SLOTS : int'(subs_reg);
      keep = (ns >= 64) ? {64{1'b1}} : ((64'd1 << ns) - 64'd1);
      r.result_id = b.update_id;
      r.match_mask = m & keep;
      expected_matches.push_back(r);
      live_mask = {64{1'b1}};
    endfunction

    // Compares one accepted output beat with the oldest owed result.
    function void check_match(rsp_t got);
      rsp_t want;
      if (expected_matches.size() == 0) begin
        $error("result with none owed: result_id %h match_mask %h",
               got.result_id, got.match_mask);
        errors++;
        return;
      end
      want = expected_matches.pop_front();
      if (got.result_id !== want.result_id) begin
        $error("result_id expected %h actual %h", want.result_id, got.result_id);
        errors++;
      end
      if (got.match_mask !== want.match_mask) begin
        $error("match_mask expected %h actual %h", want.match_mask, got.match_mask);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  match_tracker tracker;
  bit calm;
  int stall_hold;
  bit stall_next;
  int cycle_count;

  region_overlap_matcher_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 40);
  endfunction

  // Output side: check each accepted beat, then choose the next stall level.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) tracker.check_match(rsp);
    if (stall_hold == 0) begin
      stall_next = !calm && ($urandom_range(0, 2) == 0);
      stall_hold = stall_next ? gap_len() : $urandom_range(1, 6);
    end
    stall_hold--;
    rsp_stall <= stall_next;
  end

  // Coordinates cluster near zero so that overlaps are common, with the
  // extremes and the full range mixed in.
  function automatic logic signed [31:0] rand_coord();
    int r;
    int v;
    r = $urandom_range(0, 99);
    v = $urandom_range(0, 60);
    if (r < 4) return C_MIN;
    if (r < 8) return C_MAX;
    if (r < 70) return v - 30;
    return $urandom;
  endfunction

  // Mostly well-formed intervals; the rest have independent edges.
  function automatic void rand_span(output logic signed [31:0] lo,
                                    output logic signed [31:0] up);
    lo = rand_coord();
    if ($urandom_range(0, 99) < 85) up = lo + $urandom_range(0, 40);
    else up = rand_coord();
  endfunction

  function automatic req_t mk_extent(logic func, logic [5:0] slot, logic [1:0] dim,
                                     logic signed [31:0] lo, logic signed [31:0] up,
                                     logic [15:0] id);
    req_t b;
    b.func = func;
    b.slot = slot;
    b.dim = dim;
    b.lower = lo;
    b.upper = up;
    b.update_id = id;
    return b;
  endfunction

  // Presents one beat after an optional gap and holds it until accepted.
  task automatic send_extent(req_t b);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.take_extent(b);
  endtask

  // Waits until every owed result has arrived and the chain has emptied.
  task automatic settle();
    req_valid <= 1'b0;
    while (tracker.expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(bit [CFG_BITS-1:0] subs, bit [CFG_BITS-1:0] dims);
    cfg_we <= 1'b1;
    cfg_index <= REG_SUBS_IN_USE;
    cfg_data <= subs;
    @(posedge clk);
    tracker.write_reg(REG_SUBS_IN_USE, subs);
    cfg_index <= REG_DIMS_IN_USE;
    cfg_data <= dims;
    @(posedge clk);
    tracker.write_reg(REG_DIMS_IN_USE, dims);
    cfg_we <= 1'b0;
  endtask

  task automatic send_update(logic [1:0] dim, logic signed [31:0] lo,
                             logic signed [31:0] up, logic [15:0] id);
    send_extent(mk_extent(FUNC_UPDATE, 6'd0, dim, lo, up, id));
  endtask

  task automatic send_load(logic [5:0] slot, logic [1:0] dim,
                           logic signed [31:0] lo, logic signed [31:0] up);
    send_extent(mk_extent(FUNC_LOAD, slot, dim, lo, up, 16'd0));
  endtask

  initial begin
    int nd;
    int sent;
    int pick;
    int d;
    logic signed [31:0] lo;
    logic signed [31:0] up;

    tracker = new();
    clk = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_SUBS_IN_USE;
    cfg_data <= '0;
    req_valid <= 1'b0;
    req <= '0;
    rsp_stall <= 1'b0;
    calm = 1'b0;
    stall_hold = 0;
    stall_next = 1'b0;
    cycle_count = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Write every edge of every slot first, so that no unwritten entry is read.
    for (int s = 0; s < SLOTS; s++) begin
      for (int k = 0; k < DIMS; k++) begin
        rand_span(lo, up);
        send_load(6'(s), 2'(k), lo, up);
      end
    end
    settle();

    // Directed part: four slots in two dimensions.
    set_config(7'd4, 7'd2);
    send_load(6'd0, 2'd0, C_MIN, C_MAX);
    send_load(6'd0, 2'd1, 0, 0);
    send_load(6'd1, 2'd0, -10, 10);
    send_load(6'd1, 2'd1, 5, -5);
    send_load(6'd2, 2'd0, C_MAX, C_MAX);
    send_load(6'd2, 2'd1, C_MIN, C_MIN);
    send_load(6'd3, 2'd0, 100, 200);
    send_load(6'd3, 2'd1, -200, -100);
    send_update(2'd0, C_MIN, C_MIN, 16'h0000);
    send_update(2'd1, C_MIN, C_MAX, 16'h0000);
    send_update(2'd0, C_MAX, C_MAX, 16'hffff);
    send_update(2'd1, 0, 0, 16'hffff);
    send_update(2'd0, -5, 150, 16'h1234);
    send_update(2'd1, -150, 0, 16'h1234);
    // Inverted update intervals.
    send_update(2'd0, 10, -10, 16'h00aa);
    send_update(2'd1, 1, -1, 16'h00ab);
    // A second dimension-0 beat restarts the update.
    send_update(2'd0, C_MAX, C_MAX, 16'h0101);
    send_update(2'd0, -10, -10, 16'h0102);
    send_update(2'd1, -300, 300, 16'h0103);
    // Dimensions beyond the count in use are dropped.
    send_update(2'd3, C_MIN, C_MAX, 16'h5555);
    send_update(2'd2, C_MIN, C_MAX, 16'haaaa);
    // Last dimension alone completes against the reset mask.
    send_update(2'd1, -1, 1, 16'h8000);

    // Random phases, mostly whole updates with loads and stray beats mixed in.
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      set_config(PHASE_SUBS[p], PHASE_DIMS[p]);
      sent = 0;
      while (sent < BEATS_PER_PHASE) begin
        if ($urandom_range(0, 29) == 0) calm = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        nd = tracker.dims_now();
        if (pick < 75) begin
          for (int k = 0; k < nd; k++) begin
            rand_span(lo, up);
            send_extent(mk_extent(FUNC_UPDATE, 6'($urandom), 2'(k), lo, up,
                                  16'($urandom)));
          end
          sent += nd;
        end else if (pick < 90) begin
          rand_span(lo, up);
          send_extent(mk_extent(FUNC_LOAD, 6'($urandom), 2'($urandom), lo, up,
                                16'($urandom)));
          sent++;
        end else begin
          d = $urandom_range(0, 3);
          rand_span(lo, up);
          send_extent(mk_extent(FUNC_UPDATE, 6'($urandom), 2'(d), lo, up,
                                16'($urandom)));
          if (d < nd) sent++;
        end
        // Occasionally hold off until the block has delivered everything.
        if ($urandom_range(0, 199) == 0) settle();
      end
    end

    settle();
    if (tracker.errors == 0 && tracker.expected_matches.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
src/rom_pkg.sv
src/rom_cell.sv
src/rom_outreg.sv
src/region_overlap_matcher_unit.sv
dv/testbench.sv
